// File: hw/rtl/huffman_code_bit_packer_defines.svh
// assertion macros shared by the huffman code bit packer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HCBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hcbp_pkg.sv
// shared widths, opcodes and control types of the huffman code bit packer
// no dependencies
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int OP_W    = 2;
	localparam int SYM_W   = 8;
	localparam int LEN_W   = 6;
	localparam int PAT_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int PEND_W  = 7;
	localparam int CNT_W   = 3;
	localparam int DEPTH   = 256;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_PACK   = 3'b100
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic flush;
	} pack_ctrl_t;

	typedef struct packed {
		logic              emit;
		logic              last;
		logic              done;
		logic              pending;
		logic [BYTE_W-1:0] step_byte;
		logic [BYTE_W-1:0] flush_byte;
		logic [LEN_W-1:0]  remaining;
	} pack_stat_t;

endpackage

// File: hw/rtl/hcbp_in_if.sv
// input channel of the huffman code bit packer: valid/ready plus item fields
// depends on hcbp_pkg
`timescale 1ns / 1ps

interface hcbp_in_if;
	logic                        valid;
	logic                        ready;
	logic [hcbp_pkg::OP_W-1:0]   opcode;
	logic [hcbp_pkg::SYM_W-1:0]  symbol;
	logic [hcbp_pkg::LEN_W-1:0]  code_length;
	logic [hcbp_pkg::PAT_W-1:0]  code_bits;

	modport source (output valid, opcode, symbol, code_length, code_bits, input ready);
	modport sink (input valid, opcode, symbol, code_length, code_bits, output ready);
endinterface

// File: hw/rtl/hcbp_out_if.sv
// result channel of the huffman code bit packer: valid/ready plus result fields
// depends on hcbp_pkg
`timescale 1ns / 1ps

interface hcbp_out_if;
	logic                        valid;
	logic                        ready;
	logic [hcbp_pkg::BYTE_W-1:0] packed_byte;
	logic                        last_of_run;
	logic                        missing_code;

	modport source (output valid, packed_byte, last_of_run, missing_code, input ready);
	modport sink (input valid, packed_byte, last_of_run, missing_code, output ready);
endinterface

// File: hw/rtl/huffman_code_bit_packer.sv
// huffman code bit packer: a load writes a table entry and a flush emits any
// pending bits; an encode reads the table, aligns the code, then packs one digit
// of up to 8 code bits per cycle, and a symbol without code yields one error
// result. a new item is accepted only while idle with the output register free.
// one result per cycle through the output register; a stalled output holds the digit loop.
// asynchronous reset clears the table valid bits, the pending bits and the state.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hcbp_in_if.sink    items,
	hcbp_out_if.source results
);
	import hcbp_pkg::*;

	localparam int LEN_LIMIT = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;

	state_t            state_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_miss_q;

	logic              out_free;
	logic              accept;
	logic              tbl_wr;
	logic              tbl_rd;
	logic [LEN_W-1:0]  wr_len;
	logic [LEN_W-1:0]  rd_len;
	logic [PAT_W-1:0]  rd_pat;
	pack_ctrl_t        sh_ctrl;
	pack_stat_t        sh_stat;

	assign out_free    = !out_valid_q || results.ready;
	assign items.ready = (state_q == S_IDLE) && out_free;
	assign accept      = items.valid && items.ready;

	assign tbl_wr = accept && (items.opcode == OP_LOAD);
	assign tbl_rd = accept && (items.opcode == OP_ENCODE);
	assign wr_len = (int'(items.code_length) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT)
	                                                      : items.code_length;

	hcbp_code_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.wr_addr (items.symbol),
		.wr_len  (wr_len),
		.wr_pat  (items.code_bits),
		.rd_en   (tbl_rd),
		.rd_addr (items.symbol),
		.rd_len  (rd_len),
		.rd_pat  (rd_pat)
	);

	always_comb begin
		sh_ctrl.start = (state_q == S_LOOKUP) && out_free && (rd_len != '0);
		sh_ctrl.step  = (state_q == S_PACK) && out_free;
		sh_ctrl.flush = accept && (items.opcode == OP_FLUSH) && sh_stat.pending;
	end

	hcbp_bit_shifter u_shifter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sh_ctrl),
		.start_len (rd_len),
		.start_pat (rd_pat),
		.stat      (sh_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tbl_rd) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (out_free) begin
						state_q <= (rd_len == '0) ? S_IDLE : S_PACK;
					end
				end
				S_PACK: begin
					if (sh_ctrl.step && sh_stat.done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register: a new transfer loads only when the previous one is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sh_ctrl.flush
		             || ((state_q == S_LOOKUP) && out_free && (rd_len == '0))
		             || (sh_ctrl.step && sh_stat.emit)) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sh_ctrl.flush) begin
			out_byte_q <= sh_stat.flush_byte;
			out_last_q <= 1'b1;
			out_miss_q <= 1'b0;
		end else if ((state_q == S_LOOKUP) && out_free && (rd_len == '0)) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_miss_q <= 1'b1;
		end else if (sh_ctrl.step && sh_stat.emit) begin
			out_byte_q <= sh_stat.step_byte;
			out_last_q <= sh_stat.last;
			out_miss_q <= 1'b0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.packed_byte  = out_byte_q;
	assign results.last_of_run  = out_last_q;
	assign results.missing_code = out_miss_q;

	`HCBP_ASSERT_NOW(a_missing_is_zero_last, clk, arst_n,
		results.valid && results.missing_code,
		(results.packed_byte == '0) && results.last_of_run,
		"missing-code result must carry a zero byte and end its run")

	`HCBP_ASSERT_NEXT(a_pack_ends_idle, clk, arst_n,
		(state_q == S_PACK) && out_free && sh_stat.done,
		state_q == S_IDLE,
		"digit loop did not return to idle after its final step")

	`HCBP_ASSERT_NEXT(a_flush_clears_pending, clk, arst_n,
		accept && (items.opcode == OP_FLUSH),
		!sh_stat.pending,
		"pending bits remain after a flush")

	`HCBP_ASSERT_NEXT(a_stall_holds_digits, clk, arst_n,
		(state_q == S_PACK) && !out_free,
		$stable(sh_stat.remaining) && (state_q == S_PACK),
		"digit loop advanced while the result register was full")

endmodule

// File: hw/rtl/hcbp_code_table.sv
// 256-entry code table: length memory with per-entry valid bits, pattern memory
// depends on hcbp_pkg
`timescale 1ns / 1ps

module hcbp_code_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [hcbp_pkg::SYM_W-1:0]  wr_addr,
	input  logic [hcbp_pkg::LEN_W-1:0]  wr_len,
	input  logic [hcbp_pkg::PAT_W-1:0]  wr_pat,
	input  logic                        rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]  rd_addr,
	output logic [hcbp_pkg::LEN_W-1:0]  rd_len,
	output logic [hcbp_pkg::PAT_W-1:0]  rd_pat
);
	import hcbp_pkg::*;

	logic [LEN_W-1:0] len_mem [DEPTH];
	logic [PAT_W-1:0] pat_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;
	logic [LEN_W-1:0] rd_len_q;
	logic [PAT_W-1:0] rd_pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			len_mem[wr_addr] <= wr_len;
			pat_mem[wr_addr] <= wr_pat;
		end
		if (rd_en) begin
			rd_len_q <= len_mem[rd_addr];
			rd_pat_q <= pat_mem[rd_addr];
		end
	end

	// an entry never loaded reads as length zero, i.e. no code
	assign rd_len = rd_valid_q ? rd_len_q : '0;
	assign rd_pat = rd_pat_q;

endmodule

// File: hw/rtl/hcbp_bit_shifter.sv
// digit-serial packer: left-aligned code shift register feeds up to 8 bits
// per step into the pending accumulator; depends on hcbp_pkg
`timescale 1ns / 1ps

module hcbp_bit_shifter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hcbp_pkg::pack_ctrl_t        ctrl,
	input  logic [hcbp_pkg::LEN_W-1:0]  start_len,
	input  logic [hcbp_pkg::PAT_W-1:0]  start_pat,
	output hcbp_pkg::pack_stat_t        stat
);
	import hcbp_pkg::*;

	logic [PAT_W-1:0]  code_q;
	logic [LEN_W-1:0]  rem_q;
	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [3:0]          k;
	logic [BYTE_W-1:0]   digit;
	logic [14:0]         acc;
	logic [3:0]          total;
	logic [CNT_W-1:0]    new_cnt;
	logic [PEND_W-1:0]   pend_mask;
	logic [PEND_W-1:0]   new_pend;
	logic [LEN_W-1:0]    new_rem;
	logic [LEN_W-1:0]    start_shamt;

	always_comb begin
		k         = (rem_q >= 6'd8) ? 4'd8 : {1'b0, rem_q[2:0]};
		digit     = code_q[PAT_W-1 -: BYTE_W] >> (4'd8 - k);
		acc       = ({8'd0, pend_q} << k) | {7'd0, digit};
		total     = {1'b0, cnt_q} + k;
		// total minus eight and total below eight share the low three bits
		new_cnt   = total[2:0];
		pend_mask = PEND_W'((8'd1 << new_cnt) - 8'd1);
		new_pend  = acc[PEND_W-1:0] & pend_mask;
		new_rem   = rem_q - {2'b00, k};
		start_shamt = LEN_W'(PAT_W) - start_len;
	end

	assign stat.emit       = total[3];
	assign stat.step_byte  = BYTE_W'(acc >> total[2:0]);
	assign stat.last       = (({1'b0, new_rem} + {4'd0, new_cnt}) < 7'd8);
	assign stat.done       = (new_rem == '0);
	assign stat.pending    = (cnt_q != '0);
	assign stat.flush_byte = BYTE_W'({1'b0, pend_q} << (4'd8 - {1'b0, cnt_q}));
	assign stat.remaining  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			rem_q <= start_len;
		end else if (ctrl.step) begin
			rem_q  <= new_rem;
			pend_q <= new_pend;
			cnt_q  <= new_cnt;
		end else if (ctrl.flush) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end
	end

	// code is left-aligned once so each step takes its digit from the top byte
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			code_q <= start_pat << start_shamt[4:0];
		end else if (ctrl.step) begin
			code_q <= code_q << BYTE_W;
		end
	end

endmodule

// File: tb/hcbp_stream_checker.sv
// result checker for the huffman code bit packer: tracks the code table and
// the pending bit accumulator, compares every result transfer in order
// depends on hcbp_pkg, hcbp_in_if and hcbp_out_if
`timescale 1ns / 1ps

module hcbp_stream_checker #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic clk,
	input  logic arst_n,
	hcbp_in_if   items,
	hcbp_out_if  results,
	output int   failures,
	output int   awaited
);
	import hcbp_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              last_of_run;
		logic              missing_code;
	} packed_result_t;

	// stored lengths saturate at the smaller of MAX_CODE_LEN and the pattern width
	localparam int LEN_CAP = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;

	logic [LEN_W-1:0]  code_len_tbl [DEPTH];
	logic [PAT_W-1:0]  code_pat_tbl [DEPTH];
	logic [PEND_W-1:0] held_bits;
	logic [CNT_W-1:0]  held_count;
	packed_result_t    byte_queue [$];
	packed_result_t    oldest;
	packed_result_t    seen;
	int                fail_count;

	task automatic pack_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [LEN_W-1:0] len_in, input logic [PAT_W-1:0] pat_in);
		logic [63:0] acc;
		int          len;
		int          total;
		int          emitted;
		case (op)
			OP_LOAD: begin
				code_len_tbl[sym] = (len_in > LEN_CAP) ? LEN_W'(LEN_CAP) : len_in;
				code_pat_tbl[sym] = pat_in;
			end
			OP_ENCODE: begin
				len = code_len_tbl[sym];
				if (len == 0) begin
					// no code: one error byte, accumulator untouched
					byte_queue.push_back('{8'h00, 1'b1, 1'b1});
				end else begin
					acc = (64'(held_bits) << len)
						| (64'(code_pat_tbl[sym]) & ((64'd1 << len) - 64'd1));
					total = held_count + len;
					emitted = 0;
					while (total >= 8) begin
						byte_queue.push_back('{8'(acc >> (total - 8)), 1'b0, 1'b0});
						emitted++;
						total -= 8;
					end
					if (emitted > 0)
						byte_queue[byte_queue.size() - 1].last_of_run = 1'b1;
					held_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
					held_count = CNT_W'(total);
				end
			end
			OP_FLUSH: begin
				if (held_count != 0) begin
					byte_queue.push_back('{8'({1'b0, held_bits} << (8 - held_count)),
						1'b1, 1'b0});
					held_bits = '0;
					held_count = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				code_len_tbl[i] = '0;
				code_pat_tbl[i] = '0;
			end
			held_bits = '0;
			held_count = '0;
			byte_queue.delete();
			fail_count = 0;
		end else begin
			if (items.valid && items.ready)
				pack_item(items.opcode, items.symbol, items.code_length, items.code_bits);
			if (results.valid && results.ready) begin
				seen = '{results.packed_byte, results.last_of_run, results.missing_code};
				if (byte_queue.size() == 0) begin
					$display("%0t: unexpected result: byte %h last %b missing %b",
						$time, seen.packed_byte, seen.last_of_run, seen.missing_code);
					fail_count++;
				end else begin
					oldest = byte_queue.pop_front();
					if (seen.packed_byte !== oldest.packed_byte
							|| seen.last_of_run !== oldest.last_of_run
							|| seen.missing_code !== oldest.missing_code) begin
						$display("%0t: mismatch: expected byte %h last %b missing %b, got byte %h last %b missing %b",
							$time, oldest.packed_byte, oldest.last_of_run, oldest.missing_code,
							seen.packed_byte, seen.last_of_run, seen.missing_code);
						fail_count++;
					end
				end
			end
		end
		awaited <= byte_queue.size();
		failures <= fail_count;
	end

endmodule

// File: tb/testbench.sv
// top of the huffman code bit packer testbench: clock, reset, item stimulus,
// result back-pressure, idle watchdog and verdict
// depends on hcbp_pkg, both channel interfaces, the rtl top and hcbp_stream_checker
`timescale 1ns / 1ps

module testbench;
	import hcbp_pkg::*;

	localparam int MAX_CODE_LEN = 32;
	localparam int RANDOM_ITEMS = 145;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 80;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             hold_off_due = 1'b0;
	int               failures;
	int               awaited;
	int               burst_left = 0;
	logic [SYM_W-1:0] loaded_syms [$];

	hcbp_in_if  items_ch ();
	hcbp_out_if results_ch ();

	huffman_code_bit_packer #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch)
	);

	hcbp_stream_checker #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.failures(failures),
		.awaited (awaited)
	);

	always #10 clk = ~clk;

	// offer one item and hold it until the transfer, with bursts and gaps
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				items_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		items_ch.valid       <= 1'b1;
		items_ch.opcode      <= op;
		items_ch.symbol      <= sym;
		items_ch.code_length <= len;
		items_ch.code_bits   <= pat;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic wait_for_results;
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	function automatic logic [LEN_W-1:0] random_code_length();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		else if (roll < 14)
			return LEN_W'($urandom_range(1, 12));
		else if (roll < 18)
			return LEN_W'($urandom_range(13, 32));
		else
			return LEN_W'($urandom_range(33, 63));
	endfunction

	initial begin
		int               sent;
		int               pick;
		logic [SYM_W-1:0] sym;
		items_ch.valid       <= 1'b0;
		items_ch.opcode      <= OP_LOAD;
		items_ch.symbol      <= '0;
		items_ch.code_length <= '0;
		items_ch.code_bits   <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: masking, saturation, missing codes, exact byte fits, flushes
		send_item(OP_LOAD, 8'd0, 6'd1, 32'h8000_0001);
		send_item(OP_LOAD, 8'd255, 6'd32, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 8'd128, 6'd63, 32'hA5C3_5A3C);
		send_item(OP_LOAD, 8'd64, 6'd33, 32'h0000_0001);
		send_item(OP_LOAD, 8'd3, 6'd0, 32'hFFFF_FFFF);
		send_item(OP_ENCODE, 8'd3, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd200, 6'd0, 32'h0);
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
		send_item(OP_UNUSED, 8'd255, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_ENCODE, 8'd0, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd255, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd128, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd64, 6'd0, 32'h0);
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
		send_item(OP_LOAD, 8'd1, 6'd8, 32'hFFFF_FF00);
		send_item(OP_ENCODE, 8'd1, 6'd0, 32'h0);
		send_item(OP_LOAD, 8'd2, 6'd7, 32'h0000_0055);
		send_item(OP_ENCODE, 8'd0, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd2, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd2, 6'd0, 32'h0);
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd255, 6'd0, 32'h0);
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
		send_item(OP_ENCODE, 8'd0, 6'd0, 32'h0);
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);
		wait_for_results();

		// random: mostly loads and encodes of loaded symbols, some noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == 60)
				hold_off_due <= 1'b1;
			if (sent == 110)
				wait_for_results();
			pick = $urandom_range(0, 99);
			if (pick < 20 || loaded_syms.size() == 0) begin
				sym = SYM_W'($urandom_range(0, 255));
				send_item(OP_LOAD, sym, random_code_length(), PAT_W'($urandom()));
				loaded_syms.push_back(sym);
				sent++;
			end else if (pick < 80) begin
				send_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
					LEN_W'($urandom_range(0, 63)), PAT_W'($urandom()));
				sent++;
			end else if (pick < 88) begin
				send_item(OP_ENCODE, SYM_W'($urandom_range(0, 255)),
					LEN_W'($urandom_range(0, 63)), PAT_W'($urandom()));
				sent++;
			end else if (pick < 96) begin
				send_item(OP_FLUSH, SYM_W'($urandom_range(0, 255)),
					LEN_W'($urandom_range(0, 63)), PAT_W'($urandom()));
				sent++;
			end else begin
				send_item(OP_UNUSED, SYM_W'($urandom_range(0, 255)),
					LEN_W'($urandom_range(0, 63)), PAT_W'($urandom()));
			end
		end
		send_item(OP_FLUSH, 8'd0, 6'd0, 32'h0);

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// result side: random stall modes in stretches, plus one long hold-off
	initial begin
		int mode;
		int stretch;
		bit held_done;
		mode = 0;
		stretch = 0;
		held_done = 1'b0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_due && !held_done) begin
				held_done = 1'b1;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 2);
					stretch = $urandom_range(10, 60);
				end
				stretch--;
				case (mode)
					0: results_ch.ready <= 1'b1;
					1: results_ch.ready <= 1'($urandom_range(0, 1));
					default: results_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ends the run when no transfer happens on either channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
